FILE: hdl/sepia_pkg.sv
// Package for the sepia pixel tone unit: coefficient constants and the
// truncated weighted-term function. No dependencies.
`timescale 1ns / 1ps

package sepia_pkg;

	localparam int unsigned PIX_W   = 8;
	localparam int unsigned CHANS   = 3;
	localparam int unsigned TDATA_W = 24;
	localparam int unsigned SUM_W   = 10;

	// floor(x / 1000) == (x * RECIP) >> RECIP_SHIFT for every x below 493447,
	// and every product p * k stays below 196096.
	localparam int unsigned RECIP_SHIFT = 28;
	localparam int unsigned RECIP       = 268436;
	localparam int unsigned CONST_W     = 28;
	localparam int unsigned PROD_W      = PIX_W + CONST_W;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	typedef logic [PIX_W-1:0]   pix_t;
	typedef logic [CONST_W-1:0] wconst_t;

	// Weights in thousandths pre-scaled by the reciprocal: [out channel][in channel].
	localparam wconst_t SEP_WEIGHT [CHANS][CHANS] = '{
		'{CONST_W'(393 * RECIP), CONST_W'(769 * RECIP), CONST_W'(189 * RECIP)},
		'{CONST_W'(349 * RECIP), CONST_W'(686 * RECIP), CONST_W'(168 * RECIP)},
		'{CONST_W'(272 * RECIP), CONST_W'(534 * RECIP), CONST_W'(131 * RECIP)}
	};

	// floor(p * k / 1000) through one constant multiply and a shift.
	function automatic pix_t sep_term(input pix_t p, input wconst_t w);
		logic [PROD_W-1:0] prod;
		prod = {{CONST_W{1'b0}}, p} * {{PIX_W{1'b0}}, w};
		return prod[PROD_W-1 -: PIX_W];
	endfunction

endpackage

FILE: hdl/sepia_pixel_tone_unit.sv
// Sepia pixel tone unit: input register, weighted-term logic, result register.
// Depends on sepia_pkg.
`timescale 1ns / 1ps

// Usage
//   Slave stream s_*: one RGB pixel per item, tdata = red, green, blue
//   from the lowest byte up. Master stream m_*: the sepia pixel, same layout.
//   Each output channel is the sum of three truncated weighted terms,
//   saturated at 255.
// Order: the input register loads at the accepting edge, then the result
//   register loads and m_tvalid rises; a stall holds the item in the input
//   register until the result register is free.
// Throughput: one pixel per cycle while m_tready stays high; the term
//   multiplies and saturating three-term add sit between the two registers.
// Reset: arst_n clears both valid flags; no item is held after reset.
// Stall: while m_tready is low the result register holds its item and the
//   input register can still take one more; s_tready drops only when both
//   are full and the receiver is stalled.
module sepia_pixel_tone_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [sepia_pkg::TDATA_W-1:0]  s_tdata,   // red_in, green_in, blue_in
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [sepia_pkg::TDATA_W-1:0]  m_tdata    // red_out, green_out, blue_out
);
	import sepia_pkg::*;

	logic                valid_s1;
	pix_t                pix_s1 [CHANS];
	pix_t                res_q  [CHANS];
	pix_t                res_d  [CHANS];
	logic                out_adv;
	logic                in_adv;

	assign out_adv  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || out_adv;
	assign in_adv   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_adv) begin
			for (int i = 0; i < CHANS; i++) begin
				pix_s1[i] <= s_tdata[i*PIX_W +: PIX_W];
			end
		end
	end

	for (genvar c = 0; c < CHANS; c++) begin : g_chan
		logic [SUM_W-1:0] sum;
		always_comb begin
			sum = {2'b00, sep_term(pix_s1[0], SEP_WEIGHT[c][0])}
			    + {2'b00, sep_term(pix_s1[1], SEP_WEIGHT[c][1])}
			    + {2'b00, sep_term(pix_s1[2], SEP_WEIGHT[c][2])};
			// saturate at full scale
			res_d[c] = (sum >= {2'b00, PIX_MAX}) ? PIX_MAX : sum[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (!m_tvalid || m_tready) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv) begin
			res_q <= res_d;
		end
	end

	assign m_tdata = {res_q[2], res_q[1], res_q[0]};

	// an accepted item always lands in the input register
	a_in_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted item lost at input register");

	// a waiting item moves on when the result register is free
	a_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !m_tvalid |=> m_tvalid)
		else $error("item stuck in input register");

	// a full pipeline under stall holds its input item
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_tvalid && !m_tready |=> valid_s1 && !s_tready || m_tready)
		else $error("input register dropped item under stall");

endmodule

FILE: tb/sv/tb.sv
// Testbench for sepia_pixel_tone_unit: directed and random pixels through the
// stream ports, each result checked against an in-bench sepia predictor.
// Depends on sepia_pkg and the sepia_pixel_tone_unit RTL.
`timescale 1ns / 1ps

module tb;

	import sepia_pkg::*;

	// Matches the tdata layout: red in the low byte, blue in the high byte.
	typedef struct packed {
		pix_t blue;
		pix_t green;
		pix_t red;
	} rgb_t;

	localparam int unsigned TONE_SCALE = 1000;
	localparam int unsigned RESET_CYCLES = 8;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned RAND_PER_PHASE = 330;
	localparam int unsigned REPORT_LIMIT = 10;

	// Thousandths, rows are output channels, columns are red, green, blue inputs.
	localparam int unsigned TONE_WEIGHT [3][3] = '{
		'{393, 769, 189},
		'{349, 686, 168},
		'{272, 534, 131}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;   // red_in, green_in, blue_in
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;        // red_out, green_out, blue_out

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned err_count = 0;
	rgb_t toned_q [$];

	sepia_pixel_tone_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: errors");
		$finish;
	end

	// Each channel sums three terms, each truncated on its own, then saturates.
	function automatic rgb_t predict_sepia(input rgb_t px);
		int unsigned src [3];
		int unsigned acc;
		pix_t tone [3];
		rgb_t res;
		src = '{px.red, px.green, px.blue};
		for (int c = 0; c < 3; c++) begin
			acc = 0;
			for (int i = 0; i < 3; i++)
				acc += (src[i] * TONE_WEIGHT[c][i]) / TONE_SCALE;
			tone[c] = (acc >= PIX_MAX) ? PIX_MAX : pix_t'(acc);
		end
		res.red = tone[0];
		res.green = tone[1];
		res.blue = tone[2];
		return res;
	endfunction

	always @(posedge clk) begin
		m_tready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
	end

	// Pop the oldest expectation for each result, then log each accepted pixel.
	always @(posedge clk) begin
		rgb_t got;
		rgb_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = rgb_t'(m_tdata);
			if (toned_q.size() == 0) begin
				err_count++;
				if (err_count <= REPORT_LIMIT)
					$display("unexpected result r=%0d g=%0d b=%0d", got.red, got.green,
						got.blue);
			end else begin
				want = toned_q.pop_front();
				if (got.red !== want.red || got.green !== want.green
						|| got.blue !== want.blue) begin
					err_count++;
					if (err_count <= REPORT_LIMIT)
						$display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
							want.red, want.green, want.blue, got.red, got.green, got.blue);
				end
			end
		end
		if (arst_n && s_tvalid && s_tready)
			toned_q.push_back(predict_sepia(rgb_t'(s_tdata)));
	end

	// Hold the pixel on the bus until it is taken; idle first at random.
	task automatic send_pixel(input pix_t r, input pix_t g, input pix_t b);
		rgb_t px;
		px.red = r;
		px.green = g;
		px.blue = b;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (toned_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_extremes();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd1, 8'd1, 8'd1);
		send_pixel(8'd3, 8'd2, 8'd6);
	endtask

	// Gray 189 puts the red sum at 254, gray 190 lands exactly on the limit.
	task automatic test_saturation_edge();
		send_pixel(8'd189, 8'd189, 8'd189);
		send_pixel(8'd190, 8'd190, 8'd190);
		send_pixel(8'd211, 8'd211, 8'd211);
		send_pixel(8'd212, 8'd212, 8'd212);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd255, 8'd200, 8'd255);
	endtask

	task automatic test_bit_walk();
		send_pixel(8'haa, 8'h55, 8'haa);
		send_pixel(8'h55, 8'haa, 8'h55);
		send_pixel(8'h80, 8'h01, 8'h80);
		send_pixel(8'h01, 8'h80, 8'h01);
		send_pixel(8'h0f, 8'hf0, 8'h7f);
	endtask

	// A quarter of the channel values sit in the bright range where channels saturate.
	task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct);
		pix_t ch [3];
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < RAND_PER_PHASE; n++) begin
			for (int c = 0; c < 3; c++)
				ch[c] = ($urandom_range(3) == 0) ? pix_t'($urandom_range(255, 150))
					: pix_t'($urandom_range(255));
			send_pixel(ch[0], ch[1], ch[2]);
		end
		wait_drain();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 7;
		recv_stall_pct = 77;
		test_extremes();
		test_saturation_edge();
		test_bit_walk();
		wait_drain();
		test_random(7, 77);
		test_random(77, 7);
		test_random(0, 0);
		if (err_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/sepia_pkg.sv
hdl/sepia_pixel_tone_unit.sv
tb/sv/tb.sv
